FILE: rtl/core/greedy_ancestry_consistent_matching_core_macros.svh
// assertion macros for the matching core
`ifndef GREEDY_ANCESTRY_CONSISTENT_MATCHING_CORE_MACROS_SVH
`define GREEDY_ANCESTRY_CONSISTENT_MATCHING_CORE_MACROS_SVH

// pre holds in a cycle, post holds in the same cycle
`define GACM_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("gacm check failed");

// pre holds in a cycle, post holds in the next one
`define GACM_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("gacm check failed");

`endif

FILE: rtl/core/gacm_pkg.sv
package gacm_pkg;

  localparam int NODE_SLOTS    = 32;
  localparam int NODE_W        = 5;
  localparam int CELL_W        = 10;
  localparam int WEIGHT_W      = 24;
  localparam int TOTAL_W       = 28;
  localparam int CFG_W         = 6;
  localparam int DEF_MAX_NODES = 32;

  typedef enum logic [1:0] {
    MODE_EDGE_FIRST  = 2'd0,
    MODE_EDGE_SECOND = 2'd1,
    MODE_WEIGHT      = 2'd2,
    MODE_RUN         = 2'd3
  } mode_t;

  typedef enum logic {
    REG_NODES_FIRST  = 1'b0,
    REG_NODES_SECOND = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CLOSE,
    S_SCAN,
    S_DRAIN,
    S_APPEND,
    S_SUMMARY
  } state_t;

  typedef struct packed {
    mode_t                      mode;
    logic [NODE_W-1:0]          first_index;
    logic [NODE_W-1:0]          second_index;
    logic signed [WEIGHT_W-1:0] weight;
  } cmd_t;

  typedef struct packed {
    logic               kind;
    logic [NODE_W-1:0]  row;
    logic [NODE_W-1:0]  col;
    logic [TOTAL_W-1:0] total_weight;
    logic               last;
  } result_t;

  // candidate pair moving down the cell chain
  typedef struct packed {
    logic                       valid;
    logic                       ok;
    logic [NODE_W-1:0]          row;
    logic [NODE_W-1:0]          col;
    logic signed [WEIGHT_W-1:0] weight;
  } cand_t;

  typedef struct packed {
    logic                  clear;
    logic                  load;
    logic [NODE_W-1:0]     row;
    logic [NODE_W-1:0]     col;
    logic [NODE_SLOTS-1:0] row_first;
    logic [NODE_SLOTS-1:0] col_first;
    logic [NODE_SLOTS-1:0] row_second;
    logic [NODE_SLOTS-1:0] col_second;
  } cell_load_t;

  typedef struct packed {
    logic                  edge_we;
    logic [NODE_W-1:0]     parent;
    logic [NODE_W-1:0]     child;
    logic                  init;
    logic                  step_en;
    logic [NODE_W-1:0]     step_k;
    logic [NODE_SLOTS-1:0] mask;
    logic [NODE_W-1:0]     sel;
  } graph_ctl_t;

endpackage

FILE: rtl/core/gacm_graph.sv
module gacm_graph
  import gacm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  graph_ctl_t            ctl,
  output logic [NODE_SLOTS-1:0] row_out,
  output logic [NODE_SLOTS-1:0] col_out
);

  logic [NODE_SLOTS-1:0] edges [NODE_SLOTS];
  logic [NODE_SLOTS-1:0] anc   [NODE_SLOTS];
  logic [NODE_SLOTS-1:0] pivot;

  assign pivot = anc[ctl.step_k];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NODE_SLOTS; a++) begin
        edges[a] <= '0;
      end
    end else if (ctl.edge_we) begin
      edges[ctl.parent][ctl.child] <= 1'b1;
    end
  end

  // warshall: one pivot node per cycle while step_en is high, all rows in parallel
  always_ff @(posedge clk) begin
    for (int a = 0; a < NODE_SLOTS; a++) begin
      if (ctl.init) begin
        anc[a] <= ctl.mask[a]
                  ? ((NODE_SLOTS'(1) << a) | (edges[a] & ctl.mask)) : '0;
      end else if (ctl.step_en && ctl.mask[ctl.step_k] && anc[a][ctl.step_k]) begin
        anc[a] <= anc[a] | pivot;
      end
    end
  end

  always_comb begin
    row_out = anc[ctl.sel];
    for (int a = 0; a < NODE_SLOTS; a++) begin
      col_out[a] = anc[a][ctl.sel];
    end
  end

endmodule

FILE: rtl/core/gacm_cell.sv
module gacm_cell
  import gacm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_load_t ld,
  input  cand_t      cand_in,
  output cand_t      cand_out
);

  logic                  valid;
  logic [NODE_W-1:0]     row;
  logic [NODE_W-1:0]     col;
  logic [NODE_SLOTS-1:0] row_first;
  logic [NODE_SLOTS-1:0] col_first;
  logic [NODE_SLOTS-1:0] row_second;
  logic [NODE_SLOTS-1:0] col_second;
  logic                  a_ij, a_ji, a_xy, a_yx, cons;

  always_comb begin
    a_ij = col_first[cand_in.row];
    a_ji = row_first[cand_in.row];
    a_xy = col_second[cand_in.col];
    a_yx = row_second[cand_in.col];
    cons = (cand_in.row != row) && (cand_in.col != col) &&
           ((a_ij | a_ji) == (a_xy | a_yx)) && (a_ij == a_xy);
  end

  always_ff @(posedge clk) begin
    if (rst || ld.clear) begin
      valid <= 1'b0;
    end else if (ld.load) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      row        <= ld.row;
      col        <= ld.col;
      row_first  <= ld.row_first;
      col_first  <= ld.col_first;
      row_second <= ld.row_second;
      col_second <= ld.col_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out.valid <= 1'b0;
    end else begin
      cand_out.valid <= cand_in.valid;
    end
    cand_out.ok     <= cand_in.ok & (~valid | cons);
    cand_out.row    <= cand_in.row;
    cand_out.col    <= cand_in.col;
    cand_out.weight <= cand_in.weight;
  end

endmodule

FILE: rtl/core/greedy_ancestry_consistent_matching_core.sv
// Greedy ancestry-consistent matcher for two rooted DAGs. Load items (edges of either graph,
// weight cells) are written when accepted while idle. After reset the weight memory is cleared,
// all 1024 entries, with busy high. A run first builds the ancestry closure of both graphs,
// then for each accepted pair makes one full scan of the 1024-entry weight memory through the
// single read port and the consistency chain, plus one final scan that finds no pair. Each
// accepted pair is strobed on result for one cycle as soon as it is found, and the summary with
// last set ends the run; the receiver cannot stall, so every strobe is a completed transfer.
module greedy_ancestry_consistent_matching_core
  import gacm_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  cmd_t             cmd,
  output result_t          result,
  output logic             result_strobe,
  input  logic             cfg_we,
  input  reg_index_t       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int DRN_W = $clog2(MAX_NODES + 4);
  localparam logic [DRN_W-1:0] DRAIN_LEN = DRN_W'(MAX_NODES + 2);

  state_t state, state_next;

  // configuration registers
  logic [CFG_W-1:0] nodes_first, nodes_second;
  logic [CFG_W-1:0] n1, n2;
  logic [NODE_SLOTS-1:0] mask1, mask2;

  // counters
  logic [CELL_W-1:0] addr;
  logic [NODE_W-1:0] step_k;
  logic [DRN_W-1:0]  drain;
  logic [CNT_W-1:0]  count;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W:0]   total_sum;

  // best candidate of the current scan
  logic                       best_found;
  logic signed [WEIGHT_W-1:0] best_w;
  logic [NODE_W-1:0]          best_row, best_col;

  // weight memory
  logic signed [WEIGHT_W-1:0] wmem [1 << CELL_W];
  logic signed [WEIGHT_W-1:0] rd_data;
  logic [CELL_W-1:0]          rd_addr;
  logic                       rd_vld;
  logic                       mem_we;
  logic [CELL_W-1:0]          mem_waddr;
  logic signed [WEIGHT_W-1:0] mem_wdata;

  logic accept, idx_ok, run_go;
  graph_ctl_t gctl1, gctl2;
  logic [NODE_SLOTS-1:0] row1, col1, row2, col2;

  cand_t      chain [MAX_NODES + 1];
  cell_load_t ld    [MAX_NODES];

  assign accept = start & ~busy;
  assign idx_ok = ({1'b0, cmd.first_index} < CFG_W'(MAX_NODES)) &&
                  ({1'b0, cmd.second_index} < CFG_W'(MAX_NODES));
  assign run_go = accept && (cmd.mode == MODE_RUN);

  // node counts clamped into 1..MAX_NODES
  always_comb begin
    n1 = (nodes_first == '0) ? CFG_W'(1)
       : (nodes_first > CFG_W'(MAX_NODES)) ? CFG_W'(MAX_NODES) : nodes_first;
    n2 = (nodes_second == '0) ? CFG_W'(1)
       : (nodes_second > CFG_W'(MAX_NODES)) ? CFG_W'(MAX_NODES) : nodes_second;
    for (int a = 0; a < NODE_SLOTS; a++) begin
      mask1[a] = CFG_W'(a) < n1;
      mask2[a] = CFG_W'(a) < n2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_first  <= CFG_W'(NODE_SLOTS);
      nodes_second <= CFG_W'(NODE_SLOTS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NODES_FIRST:  nodes_first  <= cfg_data;
        REG_NODES_SECOND: nodes_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // graphs: edge loads, closure, ancestry lookup for the pair being appended
  always_comb begin
    gctl1.edge_we = accept && (cmd.mode == MODE_EDGE_FIRST) && idx_ok;
    gctl1.parent  = cmd.first_index;
    gctl1.child   = cmd.second_index;
    gctl1.init    = run_go;
    gctl1.step_en = (state == S_CLOSE);
    gctl1.step_k  = step_k;
    gctl1.mask    = mask1;
    gctl1.sel     = best_row;
    gctl2         = gctl1;
    gctl2.edge_we = accept && (cmd.mode == MODE_EDGE_SECOND) && idx_ok;
    gctl2.mask    = mask2;
    gctl2.sel     = best_col;
  end

  gacm_graph u_graph_first (
    .clk(clk), .rst(rst), .ctl(gctl1), .row_out(row1), .col_out(col1)
  );

  gacm_graph u_graph_second (
    .clk(clk), .rst(rst), .ctl(gctl2), .row_out(row2), .col_out(col2)
  );

  // weight memory: clearing pass after reset, loads when idle, scan reads
  always_comb begin
    mem_we    = (state == S_CLEAR) || (accept && (cmd.mode == MODE_WEIGHT) && idx_ok);
    mem_waddr = (state == S_CLEAR) ? addr : {cmd.first_index, cmd.second_index};
    mem_wdata = (state == S_CLEAR) ? '0 : cmd.weight;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wmem[mem_waddr] <= mem_wdata;
    end
    rd_data <= wmem[addr];
    rd_addr <= addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == S_SCAN);
    end
  end

  // chain entry: positive cells inside both node counts
  always_comb begin
    chain[0].valid  = rd_vld && (rd_data > 0) &&
                      ({1'b0, rd_addr[CELL_W-1:NODE_W]} < n1) &&
                      ({1'b0, rd_addr[NODE_W-1:0]} < n2);
    chain[0].ok     = 1'b1;
    chain[0].row    = rd_addr[CELL_W-1:NODE_W];
    chain[0].col    = rd_addr[NODE_W-1:0];
    chain[0].weight = rd_data;
  end

  // one cell per accepted pair, checked in sequence
  for (genvar k = 0; k < MAX_NODES; k++) begin : g_cell
    always_comb begin
      ld[k].clear      = run_go;
      ld[k].load       = (state == S_APPEND) && (count == CNT_W'(k));
      ld[k].row        = best_row;
      ld[k].col        = best_col;
      ld[k].row_first  = row1;
      ld[k].col_first  = col1;
      ld[k].row_second = row2;
      ld[k].col_second = col2;
    end

    gacm_cell u_cell (
      .clk(clk), .rst(rst), .ld(ld[k]), .cand_in(chain[k]), .cand_out(chain[k + 1])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:   if (addr == '1) state_next = S_IDLE;
      S_IDLE:    if (run_go) state_next = S_CLOSE;
      S_CLOSE:   if (step_k == '1) state_next = S_SCAN;
      S_SCAN:    if (addr == '1) state_next = S_DRAIN;
      S_DRAIN:   if (drain == DRAIN_LEN) state_next = best_found ? S_APPEND : S_SUMMARY;
      S_APPEND:  state_next = S_SCAN;
      S_SUMMARY: state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy = (state != S_IDLE);
  end

  assign total_sum = {1'b0, total} + (TOTAL_W + 1)'($unsigned(best_w));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      addr  <= '0;
      step_k <= '0;
      drain <= '0;
      count <= '0;
      total <= '0;
      best_found <= 1'b0;
      best_w <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR || state == S_SCAN) begin
        addr <= addr + 1'b1;
      end
      step_k <= (state == S_CLOSE) ? step_k + 1'b1 : '0;
      drain  <= (state == S_DRAIN) ? drain + 1'b1 : '0;
      if (run_go) begin
        count <= '0;
        total <= '0;
      end else if (state == S_APPEND) begin
        count <= count + 1'b1;
        total <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
      end
      // tracker at the chain end: strictly heavier wins, so ties keep the lowest index
      if (run_go || state == S_APPEND) begin
        best_found <= 1'b0;
        best_w     <= '0;
      end else if (chain[MAX_NODES].valid && chain[MAX_NODES].ok &&
                   (chain[MAX_NODES].weight > best_w)) begin
        best_found <= 1'b1;
        best_w     <= chain[MAX_NODES].weight;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!(run_go || state == S_APPEND) && chain[MAX_NODES].valid &&
        chain[MAX_NODES].ok && (chain[MAX_NODES].weight > best_w)) begin
      best_row <= chain[MAX_NODES].row;
      best_col <= chain[MAX_NODES].col;
    end
  end

  // result register: accepted pair or summary
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (state == S_APPEND) || (state == S_SUMMARY);
    end
    if (state == S_APPEND) begin
      result.kind         <= 1'b0;
      result.row          <= best_row;
      result.col          <= best_col;
      result.total_weight <= '0;
      result.last         <= 1'b0;
    end else begin
      result.kind         <= 1'b1;
      result.row          <= '0;
      result.col          <= '0;
      result.total_weight <= total;
      result.last         <= 1'b1;
    end
  end

  `include "greedy_ancestry_consistent_matching_core_macros.svh"

  `GACM_ASSERT_NOW(a_append_has_pair, state == S_APPEND, best_found)
  `GACM_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(MAX_NODES))
  `GACM_ASSERT_NEXT(a_summary_strobe, state == S_SUMMARY, result_strobe && result.last)
  `GACM_ASSERT_NOW(a_no_chain_when_idle, state == S_IDLE, !chain[0].valid)

endmodule
